/* hdl/cdq_pkg.sv */
// Shared constants, word types and control structs for the circular deque.
package cdq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CAP_W      = 5;

   localparam logic [1:0] CMD_PUSH_BACK  = 2'd0;
   localparam logic [1:0] CMD_POP_FRONT  = 2'd1;
   localparam logic [1:0] CMD_PUSH_FRONT = 2'd2;
   localparam logic [1:0] CMD_POP_BACK   = 2'd3;

   localparam logic [1:0] STS_DONE      = 2'd0;
   localparam logic [1:0] STS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STS_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pop_value;
      logic [1:0]         status;
      logic               is_empty;
      logic               is_full;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic exec_push;
      logic exec_pop;
      logic fault;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_push;
      logic empty;
      logic full;
   } dp_status_type;

endpackage

/* hdl/circular_deque.sv */
// Top level of the circular double-ended queue.
//
//  channel   ports                            handshake
//  -------   ------------------------------   ------------------------------------
//  request   start, busy, req_data            taken when start && !busy
//  response  rsp_valid, rsp_data              one-cycle strobe, cannot be stalled
//  config    csr_valid, csr_ready, csr_data   capacity written on valid && ready
//
// Each command steps through accept, execute (index update, slot write or
// slot read), respond. The slot memory's registered read is taken in execute and
// shows in respond; busy stays high from accept until the response strobe.
// Reset (synchronous, active high) empties the queue, homes head and tail to
// slot 0 and sets capacity to 16; slot contents are not cleared.
// rsp_valid marks the response word for exactly one cycle; the receiver cannot stall.
// Capacity writes are held off (csr_ready low) while a command is in flight.
module circular_deque (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  cdq_pkg::req_type          req_data,
   output logic                      rsp_valid,
   output cdq_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [cdq_pkg::CAP_W-1:0] csr_data
);
   import cdq_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // capacity register only takes a word while no command is in flight
   assign csr_ready = !busy;

   cdq_controller u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .status  (status),
      .busy    (busy),
      .respond (rsp_valid),
      .cmd     (cmd)
   );

   cdq_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_we   (csr_valid && csr_ready),
      .csr_data (csr_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

/* hdl/cdq_datapath.sv */
// Deque datapath: slot memory, head/tail indices, empty flag, capacity register.
module cdq_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  cdq_pkg::req_type         req_data,
   input  logic                     csr_we,
   input  logic [cdq_pkg::CAP_W-1:0] csr_data,
   input  cdq_pkg::ctrl_cmd_type    cmd,
   output cdq_pkg::dp_status_type   status,
   output cdq_pkg::rsp_type         rsp_data
);
   import cdq_pkg::*;

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [CAP_W-1:0]      capacity_ff;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic                  empty_ff, empty_in;
   logic [1:0]            command_ff;
   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  pop_ok_ff;
   logic [1:0]            status_ff;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [IDX_W-1:0]      rd_addr;
   logic                  is_push;
   logic                  full;
   logic [CAP_W-1:0]      cap_eff;

   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = CAP_W'(1);
      end else if (capacity_ff > CAP_W'(DEPTH)) begin
         cap_eff = CAP_W'(DEPTH);
      end else begin
         cap_eff = capacity_ff;
      end
   end

   // index at or past capacity wraps to slot 0
   function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] c);
      logic [CAP_W:0] nxt;
      nxt = (CAP_W+1)'(i) + (CAP_W+1)'(1);
      if (nxt >= (CAP_W+1)'(c)) begin
         return '0;
      end
      return nxt[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] i,
                                                  input logic [CAP_W-1:0] c);
      logic [CAP_W-1:0] top;
      top = c - CAP_W'(1);
      if (i == '0) begin
         return top[IDX_W-1:0];
      end
      return i - IDX_W'(1);
   endfunction

   assign is_push = (command_ff == CMD_PUSH_BACK) || (command_ff == CMD_PUSH_FRONT);
   assign full    = !empty_ff && (head_ff == step_fwd(tail_ff, cap_eff));

   assign status.is_push = is_push;
   assign status.empty   = empty_ff;
   assign status.full    = full;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      empty_in = empty_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      rd_addr  = (command_ff == CMD_POP_FRONT) ? head_ff : tail_ff;
      if (cmd.exec_push) begin
         wr_en = 1'b1;
         if (empty_ff) begin
            head_in  = '0;
            tail_in  = '0;
            empty_in = 1'b0;
            wr_addr  = '0;
         end else if (command_ff == CMD_PUSH_BACK) begin
            tail_in = step_fwd(tail_ff, cap_eff);
            wr_addr = tail_in;
         end else begin
            head_in = step_back(head_ff, cap_eff);
            wr_addr = head_in;
         end
      end else if (cmd.exec_pop) begin
         if (head_ff == tail_ff) begin
            // last element leaves: back to the reset picture
            head_in  = '0;
            tail_in  = '0;
            empty_in = 1'b1;
         end else if (command_ff == CMD_POP_FRONT) begin
            head_in = step_fwd(head_ff, cap_eff);
         end else begin
            tail_in = step_back(tail_ff, cap_eff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(DEPTH);
         head_ff     <= '0;
         tail_ff     <= '0;
         empty_ff    <= 1'b1;
         pop_ok_ff   <= 1'b0;
         status_ff   <= STS_DONE;
      end else begin
         if (csr_we) begin
            capacity_ff <= csr_data;
         end
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
         if (cmd.exec_push || cmd.exec_pop || cmd.fault) begin
            pop_ok_ff <= cmd.exec_pop;
            if (cmd.fault) begin
               status_ff <= is_push ? STS_OVERFLOW : STS_UNDERFLOW;
            end else begin
               status_ff <= STS_DONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff <= req_data.command;
         value_ff   <= DATA_WIDTH'(req_data.push_value);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      if (cmd.exec_pop) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_data.pop_value = pop_ok_ff ? 32'(signed'(rd_data_ff)) : '0;
   assign rsp_data.status    = status_ff;
   assign rsp_data.is_empty  = empty_ff;
   assign rsp_data.is_full   = full;

   a_empty_home: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == '0) && (tail_ff == '0))
      else $error("empty deque with indices off slot 0");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.exec_push |=> !empty_ff)
      else $error("deque empty after a push");

   a_fault_holds: assert property (@(posedge clock) disable iff (reset)
      cmd.fault |=> $stable(head_ff) && $stable(tail_ff) && $stable(empty_ff))
      else $error("indices moved on overflow or underflow");

endmodule

/* hdl/cdq_controller.sv */
// Deque controller: accept, execute and respond sequencing.
module cdq_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  cdq_pkg::dp_status_type status,
   output logic                   busy,
   output logic                   respond,
   output cdq_pkg::ctrl_cmd_type  cmd
);
   import cdq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      busy          = 1'b1;
      respond       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec_push = status.is_push && !status.full;
            cmd.exec_pop  = !status.is_push && !status.empty;
            cmd.fault     = status.is_push ? status.full : status.empty;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            respond  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> state_ff == ST_EXEC)
      else $error("accepted word not executed");

   a_exec_once: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.exec_push, cmd.exec_pop, cmd.fault}))
      else $error("conflicting datapath commands");

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |=> respond)
      else $error("execute not followed by response");

endmodule

/* test/circular_deque_tb.sv */
// Self-checking testbench for the circular deque: directed and random commands, live checking.
module circular_deque_tb;
   import cdq_pkg::*;

   localparam int ITEM_TARGET = 1300;
   localparam int QUIET_FROM  = 1150;     // no random sender pauses from this item on
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 8;        // settle time before missing replies are counted

   // Mirror of the deque: state, capacity and the replies still owed by the block.
   class deque_mirror;
      logic signed [DATA_WIDTH-1:0] slots [DEPTH];
      bit                           written [DEPTH];
      logic [IDX_W-1:0]             head = '0;
      logic [IDX_W-1:0]             tail = '0;
      bit                           empty = 1'b1;
      logic [CAP_W-1:0]             capacity = CAP_W'(16);
      rsp_type                      owed_replies [$];
      int                           failures = 0;

      function int eff_cap();
         if (capacity == '0) return 1;
         if (int'(capacity) > DEPTH) return DEPTH;
         return int'(capacity);
      endfunction

      function logic [IDX_W-1:0] fwd(logic [IDX_W-1:0] i);
         if (int'(i) + 1 >= eff_cap()) return '0;
         return i + 1'b1;
      endfunction

      function logic [IDX_W-1:0] back(logic [IDX_W-1:0] i);
         if (i == '0) return IDX_W'(eff_cap() - 1);
         return i - 1'b1;
      endfunction

      function bit is_full();
         return !empty && head == fwd(tail);
      endfunction

      // A pop after a capacity change could land on a slot never written.
      function bit pop_hits_unwritten(logic [1:0] cmd);
         if (empty) return 1'b0;
         return !written[(cmd == CMD_POP_FRONT) ? head : tail];
      endfunction

      function void apply_command(req_type r);
         rsp_type          want;
         logic [IDX_W-1:0] at;
         want        = '0;
         want.status = STS_DONE;
         if (r.command == CMD_PUSH_BACK || r.command == CMD_PUSH_FRONT) begin
            if (is_full()) begin
               want.status = STS_OVERFLOW;
            end else begin
               if (empty) begin
                  head  = '0;
                  tail  = '0;
                  empty = 1'b0;
                  at    = '0;
               end else if (r.command == CMD_PUSH_BACK) begin
                  tail = fwd(tail);
                  at   = tail;
               end else begin
                  head = back(head);
                  at   = head;
               end
               slots[at]   = r.push_value;
               written[at] = 1'b1;
            end
         end else begin
            if (empty) begin
               want.status = STS_UNDERFLOW;
            end else begin
               at             = (r.command == CMD_POP_FRONT) ? head : tail;
               want.pop_value = slots[at];
               if (head == tail) begin
                  head  = '0;
                  tail  = '0;
                  empty = 1'b1;
               end else if (r.command == CMD_POP_FRONT) begin
                  head = fwd(head);
               end else begin
                  tail = back(tail);
               end
            end
         end
         want.is_empty = empty;
         want.is_full  = is_full();
         owed_replies.push_back(want);
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (owed_replies.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected reply: pop=%h sts=%0d emp=%0b full=%0b",
                        got.pop_value, got.status, got.is_empty, got.is_full);
            return;
         end
         want = owed_replies.pop_front();
         if (got.pop_value !== want.pop_value || got.status !== want.status ||
             got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: exp pop=%h sts=%0d emp=%0b full=%0b, got pop=%h sts=%0d emp=%0b full=%0b",
                        want.pop_value, want.status, want.is_empty, want.is_full,
                        got.pop_value, got.status, got.is_empty, got.is_full);
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_data = '0;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data = '0;

   deque_mirror mirror = new;
   int          items_sent = 0;
   int          cycle_count = 0;

   circular_deque u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Reply strobe cannot be stalled: take every word as it goes by.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         mirror.check_reply(rsp_data);
   end

   // Present one command and hold it until taken; start stays high for a follow-on.
   task automatic issue(input logic [1:0] cmd, input logic signed [31:0] val);
      req_type r;
      if ((cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK) && mirror.pop_hits_unwritten(cmd))
         cmd = CMD_PUSH_BACK;
      r.command    = cmd;
      r.push_value = val;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      mirror.apply_command(r);
      items_sent++;
   endtask

   task automatic pause(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop start and sit until every owed reply is back.
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (mirror.owed_replies.size() != 0);
   endtask

   task automatic set_capacity(input logic [CAP_W-1:0] cap);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      mirror.capacity = cap;
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 31))
         0:       return 32'sh0000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return 32'sh8000_0000;
         3:       return 32'shFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // bias: percent of pushes
   function automatic logic [1:0] pick_cmd(input int push_pct);
      if ($urandom_range(1, 100) <= push_pct)
         return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
   endfunction

   function automatic logic [CAP_W-1:0] pick_capacity();
      case ($urandom_range(0, 9))
         0:       return CAP_W'(0);
         1:       return CAP_W'(31);
         2:       return CAP_W'(16);
         3:       return CAP_W'(1);
         8, 9:    return CAP_W'($urandom_range(0, 31));
         default: return CAP_W'($urandom_range(2, 5));
      endcase
   endfunction

   initial begin
      int n;
      int push_pct;
      int gap_pct;
      int drain_at;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: underflow both ends, extreme values, drain to empty
      issue(CMD_POP_FRONT,  32'sh1234_5678);
      issue(CMD_POP_BACK,   32'shFFFF_FFFF);
      issue(CMD_PUSH_BACK,  32'sh7FFF_FFFF);
      issue(CMD_PUSH_FRONT, 32'sh8000_0000);
      issue(CMD_PUSH_BACK,  32'shFFFF_FFFF);
      issue(CMD_PUSH_FRONT, 32'sh0000_0000);
      issue(CMD_POP_FRONT,  32'sh0000_0000);
      issue(CMD_POP_BACK,   32'sh7FFF_FFFF);
      issue(CMD_POP_FRONT,  32'shAAAA_AAAA);
      issue(CMD_POP_BACK,   32'sh5555_5555);   // last element out, head/tail home
      issue(CMD_POP_BACK,   32'sh0000_0000);

      // capacity zero acts as one slot
      wait_drained();
      set_capacity(CAP_W'(0));
      issue(CMD_PUSH_FRONT, 32'sh5555_5555);
      issue(CMD_PUSH_BACK,  32'sh0BAD_F00D);   // overflow
      issue(CMD_POP_FRONT,  32'sh0000_0000);
      issue(CMD_PUSH_BACK,  32'shAAAA_AAAA);

      // grow while holding one element; front push wraps to capacity - 1
      wait_drained();
      set_capacity(CAP_W'(3));
      issue(CMD_PUSH_FRONT, 32'sh0000_0001);
      issue(CMD_PUSH_BACK,  32'sh0000_0002);
      issue(CMD_PUSH_BACK,  32'sh0000_0003);   // overflow
      issue(CMD_POP_BACK,   32'sh0000_0000);
      issue(CMD_POP_FRONT,  32'sh0000_0000);

      // above depth clamps to depth
      wait_drained();
      set_capacity(CAP_W'(31));
      issue(CMD_PUSH_BACK,  32'shCAFE_0001);
      issue(CMD_POP_FRONT,  32'sh0000_0000);
      issue(CMD_POP_BACK,   32'sh0000_0000);

      // --- random phases, each with its own capacity and push/pop bias
      while (items_sent < ITEM_TARGET) begin
         wait_drained();
         set_capacity(pick_capacity());
         n = $urandom_range(20, 90);
         case ($urandom_range(0, 2))
            0:       push_pct = 70;
            1:       push_pct = 30;
            default: push_pct = 50;
         endcase
         gap_pct  = ($urandom_range(0, 3) == 0) ? 0 : 20;
         drain_at = $urandom_range(0, n - 1);
         for (int i = 0; i < n && items_sent < ITEM_TARGET; i++) begin
            if (items_sent < QUIET_FROM && $urandom_range(1, 100) <= gap_pct)
               pause($urandom_range(1, 11));
            else if (i == drain_at && $urandom_range(0, 1))
               wait_drained();
            issue(pick_cmd(push_pct), pick_value());
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      while (mirror.owed_replies.size() != 0) begin
         void'(mirror.owed_replies.pop_front());
         mirror.failures++;
         if (mirror.failures <= 10)
            $display("reply never arrived");
      end

      if (mirror.failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* circular_deque.f */
hdl/cdq_pkg.sv
hdl/cdq_datapath.sv
hdl/cdq_controller.sv
hdl/circular_deque.sv
test/circular_deque_tb.sv
